/* hw/rtl/lsfe_pkg.sv */
// shared types and constants for the lsb stego frame extractor
package lsfe_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SKIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd2;

  // configuration reset values
  localparam logic [BYTE_W-1:0] HEADER_SKIP_RST  = 8'd54;
  localparam logic [BYTE_W-1:0] MAGIC_FIRST_RST  = 8'd35;
  localparam logic [BYTE_W-1:0] MAGIC_SECOND_RST = 8'd42;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_EXT       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MAGIC_ERR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY_END = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] header_skip;
    logic [BYTE_W-1:0] magic_first;
    logic [BYTE_W-1:0] magic_second;
  } lsfe_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cover_byte;
    logic              start_of_image;
  } lsfe_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic              run_last;
  } lsfe_res_t;

endpackage

/* hw/rtl/lsfe_if.sv */
// valid/ready channel interfaces for file bytes in and decoded words out
interface lsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cover_byte;
  logic       start_of_image;

  modport source (output valid, output cover_byte, output start_of_image, input ready);
  modport sink (input valid, input cover_byte, input start_of_image, output ready);
endinterface

interface lsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;

  modport source (output valid, output out_byte, output kind, output run_last, input ready);
  modport sink (input valid, input out_byte, input kind, input run_last, output ready);
endinterface

/* hw/rtl/lsfe_in_reg.sv */
// input register stage holding one accepted file byte
module lsfe_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lsfe_pkg::lsfe_item_t in_item,
  input  logic                advance,
  output logic                in_ready,
  output logic                item_vld,
  output lsfe_pkg::lsfe_item_t item
);
  import lsfe_pkg::*;

  logic       vld_r;
  lsfe_item_t item_r;

  assign in_ready = !vld_r || advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end
endmodule

/* hw/rtl/lsfe_core.sv */
// frame parser: header skip, bit gathering, magic check and run counting
module lsfe_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  lsfe_pkg::lsfe_item_t item,
  input  lsfe_pkg::lsfe_cfg_t  cfg,
  output logic                 res_vld,
  output lsfe_pkg::lsfe_res_t  res
);
  import lsfe_pkg::*;

  localparam int BC_W = $clog2(LENGTH_BITS);
  localparam logic [BC_W-1:0] BYTE_LAST = BC_W'(BYTE_W - 1);
  localparam logic [BC_W-1:0] LEN_LAST  = BC_W'(LENGTH_BITS - 1);

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_MAGIC   = 8'b0000_0010,
    PH_EXTLEN  = 8'b0000_0100,
    PH_EXT     = 8'b0000_1000,
    PH_DATALEN = 8'b0001_0000,
    PH_DATA    = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_HALT    = 8'b1000_0000
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_e;
  logic [BYTE_W-1:0]      hcount_r, hcount_nxt, hcount_e;
  logic [BC_W-1:0]        bcount_r, bcount_nxt, bcount_e;
  logic [LENGTH_BITS-1:0] shift_r, shift_nxt, shift_e;
  logic                   midx_r, midx_nxt, midx_e;
  logic                   mbad_r, mbad_nxt, mbad_e;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt, remain_e, remain_dec;
  logic [LENGTH_BITS-1:0] gathered;
  logic                   byte_done, len_done, sof;
  lsfe_res_t              res_c;
  logic                   res_vld_c;

  assign sof = item.start_of_image;

  always_comb begin
    // a start flag restarts parsing on this very byte
    phase_e  = sof ? PH_HEADER : phase_r;
    hcount_e = sof ? '0 : hcount_r;
    bcount_e = sof ? '0 : bcount_r;
    shift_e  = sof ? '0 : shift_r;
    midx_e   = sof ? 1'b0 : midx_r;
    mbad_e   = sof ? 1'b0 : mbad_r;
    remain_e = sof ? '0 : remain_r;

    gathered   = shift_e | ({{(LENGTH_BITS-1){1'b0}}, item.cover_byte[0]} << bcount_e);
    byte_done  = (bcount_e == BYTE_LAST);
    len_done   = (bcount_e == LEN_LAST);
    remain_dec = remain_e - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    phase_nxt  = phase_e;
    hcount_nxt = hcount_e;
    bcount_nxt = bcount_e;
    shift_nxt  = shift_e;
    midx_nxt   = midx_e;
    mbad_nxt   = mbad_e;
    remain_nxt = remain_e;
    res_vld_c  = 1'b0;
    res_c      = '0;

    if (phase_e == PH_HEADER) begin
      if (hcount_e < cfg.header_skip) begin
        hcount_nxt = hcount_e + 8'd1;
      end else begin
        phase_nxt = PH_MAGIC;
      end
    end

    // bit gatherer for phases that collect hidden bits
    if (phase_nxt == PH_MAGIC || phase_nxt == PH_EXT || phase_nxt == PH_DATA) begin
      if (byte_done) begin
        shift_nxt  = '0;
        bcount_nxt = '0;
      end else begin
        shift_nxt  = gathered;
        bcount_nxt = bcount_e + BC_W'(1);
      end
    end else if (phase_nxt == PH_EXTLEN || phase_nxt == PH_DATALEN) begin
      if (len_done) begin
        shift_nxt  = '0;
        bcount_nxt = '0;
      end else begin
        shift_nxt  = gathered;
        bcount_nxt = bcount_e + BC_W'(1);
      end
    end

    unique case (phase_nxt)
      PH_HEADER, PH_DONE, PH_HALT: begin
      end
      PH_MAGIC: begin
        if (byte_done) begin
          if (!midx_e) begin
            mbad_nxt = (gathered[BYTE_W-1:0] != cfg.magic_first);
            midx_nxt = 1'b1;
          end else begin
            midx_nxt = 1'b0;
            if (mbad_e || gathered[BYTE_W-1:0] != cfg.magic_second) begin
              phase_nxt      = PH_HALT;
              res_vld_c      = 1'b1;
              res_c.out_byte = '0;
              res_c.kind     = KIND_MAGIC_ERR;
              res_c.run_last = 1'b0;
            end else begin
              phase_nxt = PH_EXTLEN;
            end
          end
        end
      end
      PH_EXTLEN: begin
        if (len_done) begin
          remain_nxt = gathered;
          phase_nxt  = (gathered != '0) ? PH_EXT : PH_DATALEN;
        end
      end
      PH_EXT: begin
        if (byte_done) begin
          remain_nxt     = remain_dec;
          res_vld_c      = 1'b1;
          res_c.out_byte = gathered[BYTE_W-1:0];
          res_c.kind     = KIND_EXT;
          res_c.run_last = (remain_dec == '0);
          if (remain_dec == '0) begin
            phase_nxt = PH_DATALEN;
          end
        end
      end
      PH_DATALEN: begin
        if (len_done) begin
          remain_nxt = gathered;
          if (gathered == '0) begin
            phase_nxt      = PH_DONE;
            res_vld_c      = 1'b1;
            res_c.out_byte = '0;
            res_c.kind     = KIND_EMPTY_END;
            res_c.run_last = 1'b0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (byte_done) begin
          remain_nxt     = remain_dec;
          res_vld_c      = 1'b1;
          res_c.out_byte = gathered[BYTE_W-1:0];
          res_c.kind     = KIND_DATA;
          res_c.run_last = (remain_dec == '0);
          if (remain_dec == '0) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  assign res_vld = res_vld_c;
  assign res     = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hcount_r <= '0;
      bcount_r <= '0;
      shift_r  <= '0;
      midx_r   <= 1'b0;
      mbad_r   <= 1'b0;
      remain_r <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      bcount_r <= bcount_nxt;
      shift_r  <= shift_nxt;
      midx_r   <= midx_nxt;
      mbad_r   <= mbad_nxt;
      remain_r <= remain_nxt;
    end
  end
endmodule

/* hw/rtl/lsfe_out_reg.sv */
// result register that holds a decoded word until the sink takes it
module lsfe_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                res_vld,
  input  lsfe_pkg::lsfe_res_t res,
  input  logic                out_ready,
  output logic                out_vld,
  output lsfe_pkg::lsfe_res_t out_res
);
  import lsfe_pkg::*;

  logic      vld_r;
  lsfe_res_t res_r;

  assign out_vld = vld_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= res_vld;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end
endmodule

/* hw/rtl/lsb_stego_frame_extractor.sv */
// top level: recovers a frame hidden in the low bits of an image byte stream
// an accepted word waits in the input register until the parser steps, then its result enters the result register
// throughput: one file byte per cycle, set by the single-pass parser between
// the input register and the result register; stalls only when the result waits
// reset: synchronous, clears parser state and loads the default configuration
// an item that produces no result still passes both registers and drops out
module lsb_stego_frame_extractor #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsfe_in_if.sink                         in_ch,
  lsfe_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsfe_pkg::BYTE_W-1:0]     cfg_wdata
);
  import lsfe_pkg::*;

  lsfe_cfg_t  cfg_r;
  lsfe_item_t in_item, item;
  lsfe_res_t  res, out_res;
  logic       item_vld, advance, res_vld, out_vld, in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_skip  <= HEADER_SKIP_RST;
      cfg_r.magic_first  <= MAGIC_FIRST_RST;
      cfg_r.magic_second <= MAGIC_SECOND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HEADER_SKIP:  cfg_r.header_skip  <= cfg_wdata;
        CFG_MAGIC_FIRST:  cfg_r.magic_first  <= cfg_wdata;
        CFG_MAGIC_SECOND: cfg_r.magic_second <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_item.cover_byte     = in_ch.cover_byte;
  assign in_item.start_of_image = in_ch.start_of_image;
  assign in_ch.ready            = in_ready;

  // parser steps only when the result slot is free or draining
  assign advance = item_vld && (!out_vld || out_ch.ready);

  lsfe_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_ready (in_ready),
    .item_vld (item_vld),
    .item     (item)
  );

  lsfe_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  lsfe_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_vld   (out_vld),
    .out_res   (out_res)
  );

  assign out_ch.valid    = out_vld;
  assign out_ch.out_byte = out_res.out_byte;
  assign out_ch.kind     = out_res.kind;
  assign out_ch.run_last = out_res.run_last;

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == KIND_MAGIC_ERR || out_ch.kind == KIND_EMPTY_END)
    |-> (out_ch.out_byte == '0) && !out_ch.run_last)
    else $error("marker word carries a byte or a last flag");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld |-> in_ch.ready)
    else $error("empty input stage refuses a word");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while both stages are blocked");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("pending result dropped");
endmodule

/* tb/lsfe_frame_checker.sv */
// scoreboard for the frame extractor: mirrors the hidden-bit parser and checks each decoded word
module lsfe_frame_checker #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_cover_byte,
  input  logic       in_start_of_image,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_kind,
  input  logic       out_run_last,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         errors,
  output int         pending
);
  import lsfe_pkg::*;

  typedef enum logic [2:0] {
    SCAN_HEADER, SCAN_MAGIC, SCAN_EXT_LEN, SCAN_EXT,
    SCAN_DATA_LEN, SCAN_DATA, SCAN_DONE, SCAN_HALT
  } scan_phase_t;

  localparam logic [31:0] LEN_MASK =
    (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << LENGTH_BITS) - 32'd1);

  // register copies
  logic [7:0]  hdr_skip, magic_a, magic_b;

  // parser copy
  scan_phase_t scan_phase;
  logic [7:0]  hdr_cnt;
  logic [4:0]  bit_cnt;
  logic [31:0] shift_acc;
  logic [31:0] got_val;
  logic        magic_idx;
  logic        magic_bad;
  logic [31:0] remaining;

  lsfe_res_t   hidden_words_q[$];
  lsfe_res_t   want;
  int          fail_cnt = 0;

  function automatic void restart_scan();
    scan_phase = SCAN_HEADER;
    hdr_cnt    = '0;
    bit_cnt    = '0;
    shift_acc  = '0;
    magic_idx  = 1'b0;
    magic_bad  = 1'b0;
    remaining  = '0;
  endfunction

  // shifts one hidden bit in, lsb first; true once 'need' bits are held in got_val
  function automatic bit take_bit(logic b, int need);
    shift_acc = shift_acc | (32'(b) << bit_cnt);
    if (int'(bit_cnt) + 1 >= need) begin
      got_val   = shift_acc;
      shift_acc = '0;
      bit_cnt   = '0;
      return 1'b1;
    end
    bit_cnt = bit_cnt + 5'd1;
    return 1'b0;
  endfunction

  function automatic void expect_word(logic [7:0] b, logic [1:0] k, logic last);
    lsfe_res_t w;
    w.out_byte = b;
    w.kind     = k;
    w.run_last = last;
    hidden_words_q.push_back(w);
  endfunction

  function automatic void decode_cover_byte(logic [7:0] cb, logic sop);
    if (sop)
      restart_scan();
    if (scan_phase == SCAN_HEADER && hdr_cnt < hdr_skip) begin
      hdr_cnt = hdr_cnt + 8'd1;
    end else begin
      if (scan_phase == SCAN_HEADER)
        scan_phase = SCAN_MAGIC;
      case (scan_phase)
        SCAN_MAGIC: begin
          if (take_bit(cb[0], 8)) begin
            if (!magic_idx) begin
              magic_bad = (got_val[7:0] != magic_a);
              magic_idx = 1'b1;
            end else begin
              magic_idx = 1'b0;
              if (magic_bad || got_val[7:0] != magic_b) begin
                scan_phase = SCAN_HALT;
                expect_word(8'd0, KIND_MAGIC_ERR, 1'b0);
              end else begin
                scan_phase = SCAN_EXT_LEN;
              end
            end
          end
        end
        SCAN_EXT_LEN: begin
          if (take_bit(cb[0], LENGTH_BITS)) begin
            remaining  = got_val & LEN_MASK;
            scan_phase = (remaining != 0) ? SCAN_EXT : SCAN_DATA_LEN;
          end
        end
        SCAN_EXT: begin
          if (take_bit(cb[0], 8)) begin
            remaining = remaining - 32'd1;
            if (remaining == 0)
              scan_phase = SCAN_DATA_LEN;
            expect_word(got_val[7:0], KIND_EXT, remaining == 0);
          end
        end
        SCAN_DATA_LEN: begin
          if (take_bit(cb[0], LENGTH_BITS)) begin
            remaining = got_val & LEN_MASK;
            if (remaining == 0) begin
              scan_phase = SCAN_DONE;
              expect_word(8'd0, KIND_EMPTY_END, 1'b0);
            end else begin
              scan_phase = SCAN_DATA;
            end
          end
        end
        SCAN_DATA: begin
          if (take_bit(cb[0], 8)) begin
            remaining = remaining - 32'd1;
            if (remaining == 0)
              scan_phase = SCAN_DONE;
            expect_word(got_val[7:0], KIND_DATA, remaining == 0);
          end
        end
        default: ;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_skip = HEADER_SKIP_RST;
      magic_a  = MAGIC_FIRST_RST;
      magic_b  = MAGIC_SECOND_RST;
      restart_scan();
      hidden_words_q.delete();
    end else begin
      // a result leaving now always belongs to an earlier word, so check before predicting
      if (out_valid && out_ready) begin
        if (hidden_words_q.size() == 0) begin
          $error("unexpected word: out_byte %0d kind %0d run_last %0d",
                 out_byte, out_kind, out_run_last);
          fail_cnt++;
        end else begin
          want = hidden_words_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, out_byte);
            fail_cnt++;
          end
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            fail_cnt++;
          end
          if (out_run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_run_last);
            fail_cnt++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HEADER_SKIP:  hdr_skip = cfg_wdata;
          CFG_MAGIC_FIRST:  magic_a  = cfg_wdata;
          CFG_MAGIC_SECOND: magic_b  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        decode_cover_byte(in_cover_byte, in_start_of_image);
    end
    pending <= hidden_words_q.size();
    errors  <= fail_cnt;
  end

endmodule

/* tb/tb_lsb_stego_frame_extractor.sv */
// top of the frame extractor testbench: clock, reset, image byte stimulus and verdict
module tb_lsb_stego_frame_extractor;
  import lsfe_pkg::*;

  localparam int LEN_BITS    = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  lsfe_in_if  in_ch();
  lsfe_out_if out_ch();

  int   errors;
  int   pending;
  int   items_sent   = 0;
  int   cycle_cnt    = 0;
  logic sop_pending  = 1'b0;
  logic steady       = 1'b0;

  // current register values, for building frames that match
  logic [7:0] cur_hdr, cur_m1, cur_m2;

  lsb_stego_frame_extractor #(.LENGTH_BITS(LEN_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lsfe_frame_checker #(.LENGTH_BITS(LEN_BITS)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_cover_byte     (in_ch.cover_byte),
    .in_start_of_image (in_ch.start_of_image),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_byte          (out_ch.out_byte),
    .out_kind          (out_ch.kind),
    .out_run_last      (out_ch.run_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .errors            (errors),
    .pending           (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_lsb_stego_frame_extractor: done, errors");
      $finish;
    end
  end

  // one file byte; random idle cycles ahead of it unless steady, held until taken
  task automatic put_byte(input logic [7:0] cb);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(0, 99) < 26) begin
        in_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid          = 1'b1;
    in_ch.cover_byte     = cb;
    in_ch.start_of_image = sop_pending;
    sop_pending          = 1'b0;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hides nbits of v, lsb first, under random upper bits
  task automatic put_hidden(input logic [31:0] v, input int nbits);
    for (int i = 0; i < nbits; i++)
      put_byte({7'($urandom), v[i]});
  endtask

  task automatic put_lead(input logic with_sop, input logic [7:0] m1, input logic [7:0] m2);
    sop_pending = with_sop;
    repeat (cur_hdr) put_byte(8'($urandom));
    put_hidden({24'd0, m1}, 8);
    put_hidden({24'd0, m2}, 8);
  endtask

  // length field then that many random bytes
  task automatic put_run(input int n);
    put_hidden(32'(n), 32);
    repeat (n) put_hidden($urandom, 8);
  endtask

  task automatic put_frame(input logic with_sop, input int ext_n, input int data_n);
    put_lead(with_sop, cur_m1, cur_m2);
    put_run(ext_n);
    put_run(data_n);
  endtask

  // stop sending and wait until every predicted word has come out
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [7:0] m1, input logic [7:0] m2);
    drain();
    write_reg(CFG_HEADER_SKIP, hdr);
    write_reg(CFG_MAGIC_FIRST, m1);
    write_reg(CFG_MAGIC_SECOND, m2);
    cur_hdr = hdr;
    cur_m1  = m1;
    cur_m2  = m2;
  endtask

  task automatic run_random(input int budget);
    int start_items;
    int r;
    int sel;
    logic [7:0] b1, b2;
    start_items = items_sent;
    while (items_sent - start_items < budget) begin
      r = $urandom_range(0, 99);
      if (r < 66) begin
        put_frame(1'b1,
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4),
                  ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6));
      end else if (r < 76) begin
        // wrong first, second or both magic bytes
        sel = $urandom_range(0, 2);
        b1  = cur_m1 ^ ((sel != 1) ? 8'($urandom_range(1, 255)) : 8'd0);
        b2  = cur_m2 ^ ((sel != 0) ? 8'($urandom_range(1, 255)) : 8'd0);
        put_lead(1'b1, b1, b2);
      end else if (r < 88) begin
        // frame cut short by the next start mark, often with a huge length
        put_lead(1'b1, cur_m1, cur_m2);
        if ($urandom_range(0, 1) == 0) begin
          put_hidden($urandom, $urandom_range(0, 32));
          put_hidden($urandom, $urandom_range(0, 16));
        end else begin
          put_hidden(32'd0, 32);
          put_hidden($urandom | 32'd1, 32);
          put_hidden($urandom, $urandom_range(0, 24));
        end
      end else if (r < 96) begin
        repeat ($urandom_range(1, 20)) begin
          sop_pending = ($urandom_range(0, 9) == 0);
          put_byte(8'($urandom));
        end
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = CFG_HEADER_SKIP;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.cover_byte     = '0;
    in_ch.start_of_image = 1'b0;
    out_ch.ready         = 1'b0;
    cur_hdr              = HEADER_SKIP_RST;
    cur_m1               = MAGIC_FIRST_RST;
    cur_m2               = MAGIC_SECOND_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values, first file without a start mark, then an empty data run
    put_frame(1'b0, 2, 3);
    put_frame(1'b1, 0, 0);
    drain();

    // no header, extreme magic values
    set_config(8'd0, 8'h00, 8'hFF);
    put_frame(1'b1, 1, 1);
    put_lead(1'b1, 8'h01, 8'hFF);
    put_frame(1'b0, 1, 1);          // ignored while halted
    put_lead(1'b1, 8'h00, 8'h7F);
    put_lead(1'b1, 8'hFF, 8'h00);
    put_frame(1'b1, 0, 2);
    put_run(2);                     // ignored once the frame is done
    put_frame(1'b1, 3, 0);

    // longest header
    set_config(8'd255, 8'hFF, 8'h00);
    put_frame(1'b1, 3, 1);

    set_config(8'($urandom_range(0, 10)), 8'($urandom), 8'($urandom));
    run_random(20);

    // a stretch with neither side idling
    set_config(8'($urandom_range(1, 6)), 8'($urandom), 8'($urandom));
    steady = 1'b1;
    run_random(60);
    drain();
    steady = 1'b0;

    set_config(8'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    run_random(20);

    drain();
    if (errors == 0 && pending == 0)
      $display("tb_lsb_stego_frame_extractor: done, clean");
    else
      $display("tb_lsb_stego_frame_extractor: done, errors");
    $finish;
  end

endmodule

/* lsb_stego_frame_extractor.f */
hw/rtl/lsfe_pkg.sv
hw/rtl/lsfe_if.sv
hw/rtl/lsfe_in_reg.sv
hw/rtl/lsfe_core.sv
hw/rtl/lsfe_out_reg.sv
hw/rtl/lsb_stego_frame_extractor.sv
tb/lsfe_frame_checker.sv
tb/tb_lsb_stego_frame_extractor.sv
